[sv/positional_list_store_assert.svh]
// Assertion macros shared by the list store RTL.
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

// Check on every clock edge outside reset.
`define PLS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define PLS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/pls_pkg.sv]
// Shared constants, codes and types for the positional list store.
package pls_pkg;

  localparam int DEPTH      = 16;
  localparam int FUNC_W     = 2;
  localparam int POS_W      = 6;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 5;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W      = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_DELETE = 2'd1,
    FN_FIND   = 2'd2,
    FN_READ   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_BEYOND   = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CM_HOLD  = 2'd0,
    CM_LOAD  = 2'd1,
    CM_LEFT  = 2'd2,
    CM_RIGHT = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t               mode;
    logic [VALUE_W-1:0]       value;
  } cell_ctrl_t;

endpackage

[sv/pls_cell.sv]
// One list entry: holds, loads, or takes a neighbor's entry, and compares against the key.
module pls_cell (
  input  logic                        clk,
  input  pls_pkg::cell_ctrl_t         ctrl,
  input  logic [pls_pkg::VALUE_W-1:0] left,
  input  logic [pls_pkg::VALUE_W-1:0] right,
  output logic [pls_pkg::VALUE_W-1:0] entry,
  output logic                        match
);
  import pls_pkg::*;

  always_ff @(posedge clk) begin
    unique case (ctrl.mode)
      CM_HOLD:  entry <= entry;
      CM_LOAD:  entry <= ctrl.value;
      CM_LEFT:  entry <= left;
      CM_RIGHT: entry <= right;
    endcase
  end

  assign match = (entry == ctrl.value);

endmodule

[sv/positional_list_store.sv]
// Top level of the positional list store: request decode, cell row and result register.
//
//   channel | dir | tdata (low bit up)                                   | tuser
//   s_*     | in  | position[5:0], value[37:6], zero pad                  | func[1:0]
//   m_*     | out | status, found_position, read_value, count, is_full,   | -
//           |     | is_empty, zero pad                                   |
//
// One request per cycle while s_tready is high; the result is registered and appears in the cycle after acceptance.
// All entries shift and compare in parallel in the cell row for insert, delete,
// find and read; the find priority pick sets the path.
// s_tready drops only while a result waits in the output register and m_tready is low.
// rst is synchronous and empties the list; entries are not cleared.
module positional_list_store (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [pls_pkg::IN_DATA_W-1:0]  s_tdata,   // position, value
  input  logic [pls_pkg::FUNC_W-1:0]     s_tuser,   // func
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [pls_pkg::OUT_DATA_W-1:0] m_tdata    // status, found_position, read_value,
                                                    // count, is_full, is_empty
);
  import pls_pkg::*;

  `include "positional_list_store_assert.svh"

  logic                  fire;
  func_t                 fn;
  logic [POS_W-1:0]      pos;
  logic [VALUE_W-1:0]    val;
  logic [CMP_W-1:0]      pos_c;
  logic [CMP_W-1:0]      cnt_c;
  logic [CMP_W-1:0]      pos_m1;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic                  do_ins;
  logic                  do_del;
  status_t               stat;
  logic [COUNT_W-1:0]    found;
  logic [VALUE_W-1:0]    rd;
  logic [VALUE_W-1:0]    cell_entry [DEPTH];
  logic [DEPTH-1:0]      cell_match;
  logic [DEPTH-1:0]      hit;
  cell_ctrl_t            cell_ctrl  [DEPTH];

  status_t               status_q;
  logic [COUNT_W-1:0]    found_q;
  logic [VALUE_W-1:0]    rd_q;
  logic [COUNT_W-1:0]    count_q;
  logic                  full_q;
  logic                  empty_q;

  assign s_tready = !m_tvalid || m_tready;
  assign fire     = s_tvalid && s_tready;
  assign fn       = func_t'(s_tuser);
  assign pos      = s_tdata[POS_W-1:0];
  assign val      = s_tdata[POS_W +: VALUE_W];
  assign pos_c    = CMP_W'(pos);
  assign cnt_c    = CMP_W'(count);
  assign pos_m1   = pos_c - CMP_W'(1);

  always_comb begin
    stat   = ST_OK;
    found  = '0;
    rd     = '0;
    do_ins = 1'b0;
    do_del = 1'b0;
    unique case (fn)
      FN_INSERT: begin
        if (pos == '0)                            stat = ST_ZERO;
        else if (pos_c > cnt_c + CMP_W'(1))       stat = ST_BEYOND;
        else if (count == CNT_W'(DEPTH))          stat = ST_FULL;
        else                                      do_ins = 1'b1;
      end
      FN_DELETE: begin
        if (pos == '0)                            stat = ST_ZERO;
        else if (pos_c > cnt_c)                   stat = ST_BEYOND;
        else                                      do_del = 1'b1;
      end
      FN_FIND: begin
        stat = ST_NOTFOUND;
        for (int i = DEPTH - 1; i >= 0; i--) begin
          if (hit[i]) begin
            stat  = ST_OK;
            found = COUNT_W'(i + 1);
          end
        end
      end
      FN_READ: begin
        if (pos == '0)                            stat = ST_ZERO;
        else if (pos_c > cnt_c)                   stat = ST_BEYOND;
        else                                      rd = cell_entry[pos_m1[IDX_W-1:0]];
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (do_ins)      count_next = count + CNT_W'(1);
    else if (do_del) count_next = count - CNT_W'(1);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_W-1:0] left_in;
    logic [VALUE_W-1:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = val;
    end else begin : g_mid_l
      assign left_in = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_in = cell_entry[i];
    end else begin : g_mid_r
      assign right_in = cell_entry[i+1];
    end

    always_comb begin
      cell_ctrl[i].value = val;
      cell_ctrl[i].mode  = CM_HOLD;
      if (fire && do_ins) begin
        if (CMP_W'(i) > pos_m1)       cell_ctrl[i].mode = CM_LEFT;
        else if (CMP_W'(i) == pos_m1) cell_ctrl[i].mode = CM_LOAD;
      end else if (fire && do_del) begin
        if (CMP_W'(i) >= pos_m1)      cell_ctrl[i].mode = CM_RIGHT;
      end
    end

    assign hit[i] = cell_match[i] && (CMP_W'(i) < cnt_c);

    pls_cell u_cell (
      .clk   (clk),
      .ctrl  (cell_ctrl[i]),
      .left  (left_in),
      .right (right_in),
      .entry (cell_entry[i]),
      .match (cell_match[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_q <= stat;
      found_q  <= found;
      rd_q     <= rd;
      count_q  <= COUNT_W'(count_next);
      full_q   <= (count_next == CNT_W'(DEPTH));
      empty_q  <= (count_next == '0);
    end
  end

  assign m_tdata = {1'b0, empty_q, full_q, count_q, rd_q, found_q, status_q};

  `PLS_ASSERT(a_count_bound, count <= CNT_W'(DEPTH), "entry count above depth")
  `PLS_ASSERT(a_insert_grows, fire && do_ins |=> count == $past(count) + CNT_W'(1), "no grow")
  `PLS_ASSERT(a_fire_result, fire |=> m_tvalid, "accepted word without result")
  `PLS_ASSERT(a_full_flag, m_tvalid |-> (full_q == (count_q == COUNT_W'(DEPTH))), "full flag")

endmodule
